// ===== rtl/cls_pkg.sv =====
// Package: shared types, codes and constants of the contrast stretch block.
package cls_pkg;

  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam logic [7:0] LOW_RESET  = 8'd255;
  localparam logic [7:0] HIGH_RESET = 8'd0;

  localparam logic ACT_MEASURE = 1'b0;
  localparam logic ACT_MAP     = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel_in;
    logic       frame_start;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end_out;
  } out_item_t;

  // Divider request: start pulse with 16-bit dividend and 8-bit divisor.
  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [7:0]  den;
  } div_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } cls_state_e;

endpackage

// ===== rtl/cls_stream_if.sv =====
// Interface: valid/ready request channel with a typed payload.
interface cls_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/contrast_linear_stretch.sv =====
// Top level: linear contrast stretch of 8-bit grayscale frames.
//
// The frame is sent twice. Measure requests (action 0) update the running
// minimum and maximum in the cycle they are accepted and give no result;
// one is taken every cycle while no map request is in progress. A map
// request (action 1) gives one result, clamp((p - min) * 255 / (max - min),
// 0, 255), or p itself when max is not above min. Pixels at or below the
// minimum give 0 and at or above the maximum give 255 with no division;
// those results are registered and moved to the output register in the
// push state. Pixels strictly between go through a bit-serial restoring
// divider, one quotient bit per cycle: a load, 8 divide steps, a registered
// done flag, a capture into the result register and a push into the output
// register. The next request is taken once the controller is back in idle.
// A full output register with a stalled sink holds the controller in its
// push state for as long as the stall lasts. One request is worked on at a
// time. The result sits in an output register, so a new request is accepted
// while a finished result still waits for the sink.
module contrast_linear_stretch import cls_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  cls_stream_if.sink    in_i,
  cls_stream_if.source  out_o
);

  cls_state_e state_q, state_d;

  logic       in_acc;
  in_item_t   in_req;
  logic [7:0] low, high;
  logic       measure, map_req;
  logic       flat, at_low, at_high, need_div;
  logic [7:0] diff;
  logic [7:0] fast_res;

  div_req_t   div_req;
  logic       div_done;
  logic [7:0] div_quo;

  logic       push;
  logic [7:0] res_q, res_d;
  logic       feo_q, feo_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_data_q, out_data_d;

  assign in_req  = in_i.data;
  assign in_acc  = in_i.valid & in_i.ready;
  assign measure = in_acc & (in_req.action == ACT_MEASURE);
  assign map_req = in_acc & (in_req.action == ACT_MAP);

  cls_range u_range (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (measure),
    .restart_i (in_req.frame_start),
    .pix_i     (in_req.pixel_in),
    .low_o     (low),
    .high_o    (high)
  );

  // Trivial cases resolve without the divider.
  assign flat     = (high <= low);
  assign at_low   = (in_req.pixel_in <= low);
  assign at_high  = (in_req.pixel_in >= high);
  assign need_div = ~flat & ~at_low & ~at_high;

  always_comb begin
    if (flat)        fast_res = in_req.pixel_in;
    else if (at_low) fast_res = 8'd0;
    else             fast_res = FULL_SCALE;
  end

  // Dividend (p - min) * 255 formed as (d << 8) - d.
  assign diff          = in_req.pixel_in - low;
  assign div_req.start = map_req & need_div;
  assign div_req.num   = {diff, 8'h00} - {8'h00, diff};
  assign div_req.den   = high - low;

  cls_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (map_req) state_d = need_div ? ST_DIV : ST_PUSH;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    in_i.ready = 1'b0;
    push       = 1'b0;
    unique case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_DIV:  ;
      ST_PUSH: push = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_comb begin
    res_d = res_q;
    feo_d = feo_q;
    if (map_req) begin
      res_d = fast_res;
      feo_d = in_req.frame_end;
    end else if ((state_q == ST_DIV) && div_done) begin
      res_d = div_quo;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (push) begin
      out_valid_d              = 1'b1;
      out_data_d.pixel_out     = res_q;
      out_data_d.frame_end_out = feo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    feo_q      <= feo_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== rtl/cls_range.sv =====
// Running minimum and maximum of the measured pixels.
module cls_range import cls_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       upd_i,
  input  logic       restart_i,
  input  logic [7:0] pix_i,
  output logic [7:0] low_o,
  output logic [7:0] high_o
);

  logic [7:0] low_q, low_d;
  logic [7:0] high_q, high_d;

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (upd_i) begin
      if (restart_i) begin
        low_d  = pix_i;
        high_d = pix_i;
      end else begin
        if (pix_i < low_q)  low_d  = pix_i;
        if (pix_i > high_q) high_d = pix_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_RESET;
      high_q <= HIGH_RESET;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  assign low_o  = low_q;
  assign high_o = high_q;

endmodule

// ===== rtl/cls_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, 8 quotient bits.
// Dividend must satisfy num < den * 256.
module cls_div import cls_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  div_req_t   req_i,
  output logic       done_o,
  output logic [7:0] quo_o
);

  logic [7:0] rem_q, rem_d;
  logic [7:0] sh_q, sh_d;
  logic [7:0] quo_q, quo_d;
  logic [7:0] den_q, den_d;
  logic [2:0] cnt_q, cnt_d;
  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [9:0] diff;
  logic       ge;

  // Trial subtract of the divisor from the shifted partial remainder.
  assign diff = {1'b0, rem_q, sh_q[7]} - {2'b00, den_q};
  assign ge   = ~diff[9];

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.num[15:8];
      sh_d   = req_i.num[7:0];
      den_d  = req_i.den;
      cnt_d  = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[7:0] : {rem_q[6:0], sh_q[7]};
      sh_d  = {sh_q[6:0], 1'b0};
      quo_d = {quo_q[6:0], ge};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== test/contrast_linear_stretch_test.sv =====
// Testbench: contrast stretch block driven with random-gap requests and checked by a scoreboard.
module contrast_linear_stretch_test import cls_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 3;
  localparam int TARGET_ITEMS = 1150;
  localparam int MAX_GAP      = 12;
  // Slowest legal stretch with no handshake: sender gap + divide + sink stall,
  // all well under this.
  localparam int IDLE_LIMIT   = 2000;
  // Settle a bit longer than the divide path at the end.
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_REPORTS  = 50;

  logic clk = 1'b0;
  logic rst_n;

  cls_stream_if #(.T(in_item_t))  req_if ();
  cls_stream_if #(.T(out_item_t)) res_if ();

  contrast_linear_stretch uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Scoreboard: keeps its own running min/max and the queue of stretched
  // pixels still owed by the block.
  class stretch_scoreboard;
    logic [7:0] min_seen;
    logic [7:0] max_seen;
    out_item_t  owed_pixels[$];
    int unsigned mismatches;

    function new();
      min_seen    = LOW_RESET;
      max_seen    = HIGH_RESET;
      mismatches  = 0;
    endfunction

    // Stretch of one pixel against the current range; copy-through when the
    // range is empty (flat frame or nothing measured yet).
    function logic [7:0] stretch_of(logic [7:0] pix);
      int span;
      int scaled;
      if (max_seen <= min_seen) begin
        return pix;
      end
      span   = int'(max_seen) - int'(min_seen);
      scaled = (int'(pix) - int'(min_seen)) * int'(FULL_SCALE) / span;
      if (scaled < 0) begin
        scaled = 0;
      end
      if (scaled > int'(FULL_SCALE)) begin
        scaled = int'(FULL_SCALE);
      end
      return scaled[7:0];
    endfunction

    function void note_request(in_item_t req);
      out_item_t owed;
      if (req.action == ACT_MEASURE) begin
        if (req.frame_start) begin
          min_seen = req.pixel_in;
          max_seen = req.pixel_in;
        end else begin
          if (req.pixel_in < min_seen) begin
            min_seen = req.pixel_in;
          end
          if (req.pixel_in > max_seen) begin
            max_seen = req.pixel_in;
          end
        end
      end else begin
        owed.pixel_out     = stretch_of(req.pixel_in);
        owed.frame_end_out = req.frame_end;
        owed_pixels.push_back(owed);
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      if (mismatches < MAX_REPORTS) begin
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      end
      mismatches++;
    endtask

    task check_result(out_item_t res);
      out_item_t want;
      if (owed_pixels.size() == 0) begin
        report_mismatch("unexpected result, pixel_out", int'(res.pixel_out), -1);
        return;
      end
      want = owed_pixels.pop_front();
      if (res.pixel_out !== want.pixel_out) begin
        report_mismatch("pixel_out", int'(res.pixel_out), int'(want.pixel_out));
      end
      if (res.frame_end_out !== want.frame_end_out) begin
        report_mismatch("frame_end_out", int'(res.frame_end_out),
                        int'(want.frame_end_out));
      end
    endtask

    function int unsigned pending();
      return owed_pixels.size();
    endfunction
  endclass

  stretch_scoreboard board = new();

  bit          send_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;

  // Per-request wait, 0..MAX_GAP. Every so often a side flips into a quiet
  // spell where it never idles, so back-to-back traffic is covered too.
  function automatic int unsigned draw_gap(ref bit quiet);
    if ($urandom_range(0, 31) == 0) begin
      quiet = ~quiet;
    end
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Called at a rising edge. valid is only lowered when a gap follows, so a
  // back-to-back request never sees valid dropped and raised in one step.
  task automatic send_request(logic act, logic [7:0] pix, logic start, logic last);
    in_item_t    req;
    int unsigned gap;
    req.action      = act;
    req.pixel_in    = pix;
    req.frame_start = start;
    req.frame_end   = last;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    do @(posedge clk); while (!req_if.ready);
    board.note_request(req);
    items_sent++;
  endtask

  // Hold off new requests until the block has handed back everything owed.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // One frame sent twice, with occasional deliberate abuse:
  //   kind 1: flat frame (min == max, copy-through)
  //   kind 2: no measure pass, map against whatever range is left
  //   kind 3: measure pass without frame_start, merges with old range
  //   kind 4: map pass with arbitrary pixels, hits both clamps
  //   kind 5: pure noise, every field random
  task automatic run_frame();
    logic [7:0]  px[$];
    int unsigned kind;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    logic [7:0]  pix;
    kind = $urandom_range(0, 11);
    n    = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    lo   = $urandom_range(0, 255);
    hi   = (kind == 1) ? lo : $urandom_range(lo, 255);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0:       px.push_back(lo[7:0]);
        1:       px.push_back(hi[7:0]);
        default: px.push_back(8'($urandom_range(lo, hi)));
      endcase
    end
    if (kind == 5) begin
      for (int i = 0; i < n; i++) begin
        send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      return;
    end
    // Measure pass; frame_end here is don't-care, so sprinkle it.
    if (kind != 2) begin
      for (int i = 0; i < n; i++) begin
        send_request(ACT_MEASURE, px[i], (i == 0) && (kind != 3),
                     (i == n - 1) || ($urandom_range(0, 15) == 0));
      end
    end
    // Map pass; frame_start here is don't-care.
    for (int i = 0; i < n; i++) begin
      pix = (kind == 4) ? 8'($urandom_range(0, 255)) : px[i];
      send_request(ACT_MAP, pix, $urandom_range(0, 7) == 0, i == n - 1);
    end
  endtask

  // Sink side: random ready stalls, each result checked as it is taken.
  initial begin
    int unsigned gap;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap(sink_quiet);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      board.check_result(res_if.data);
    end
  end

  // Watchdog: counts edges with no handshake on either channel.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Main stimulus.
  initial begin
    int unsigned frames;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rst_n        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Map straight out of reset: range is {255, 0}, so pixels pass through;
    // frame_start on a map request must be ignored.
    send_request(ACT_MAP, 8'd0,   1'b1, 1'b0);
    send_request(ACT_MAP, 8'd255, 1'b0, 1'b0);
    send_request(ACT_MAP, 8'hA5,  1'b1, 1'b1);
    // Measure without frame_start merges with the reset range -> flat at 100.
    send_request(ACT_MEASURE, 8'd100, 1'b0, 1'b0);
    send_request(ACT_MEASURE, 8'd100, 1'b0, 1'b1);
    send_request(ACT_MAP, 8'd100, 1'b0, 1'b0);
    send_request(ACT_MAP, 8'h5A,  1'b0, 1'b1);
    // Range 50..200; frame_end on measure is ignored. Clamps at both sides.
    send_request(ACT_MEASURE, 8'd50,  1'b1, 1'b1);
    send_request(ACT_MEASURE, 8'd200, 1'b0, 1'b1);
    send_request(ACT_MEASURE, 8'd120, 1'b0, 1'b0);
    send_request(ACT_MAP, 8'd50,  1'b0, 1'b0);
    send_request(ACT_MAP, 8'd200, 1'b0, 1'b0);
    send_request(ACT_MAP, 8'd10,  1'b0, 1'b0);
    send_request(ACT_MAP, 8'd250, 1'b0, 1'b0);
    send_request(ACT_MAP, 8'd125, 1'b1, 1'b1);
    // Full range 0..255 restarted from the top value.
    send_request(ACT_MEASURE, 8'd255, 1'b1, 1'b0);
    send_request(ACT_MEASURE, 8'd0,   1'b0, 1'b1);
    send_request(ACT_MAP, 8'd0,   1'b0, 1'b0);
    send_request(ACT_MAP, 8'd255, 1'b0, 1'b0);
    send_request(ACT_MAP, 8'd1,   1'b0, 1'b0);
    send_request(ACT_MAP, 8'd254, 1'b0, 1'b0);
    send_request(ACT_MAP, 8'd128, 1'b0, 1'b1);
    // Narrowest non-flat range: 254..255.
    send_request(ACT_MEASURE, 8'd254, 1'b1, 1'b0);
    send_request(ACT_MEASURE, 8'd255, 1'b0, 1'b1);
    send_request(ACT_MAP, 8'd254, 1'b0, 1'b1);
    drain_results();

    frames = 0;
    while (items_sent < TARGET_ITEMS) begin
      run_frame();
      frames++;
      if (frames % 15 == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cls_pkg.sv
rtl/cls_stream_if.sv
rtl/cls_range.sv
rtl/cls_div.sv
rtl/contrast_linear_stretch.sv
test/contrast_linear_stretch_test.sv
